[hw/rtl/pfsbf_pkg.sv]
// shared types and constants for the page free space best-fit table
`default_nettype none
package pfsbf_pkg;

  localparam int ACT_W       = 2;
  localparam int ID_W        = 31;
  localparam int SPACE_W     = 15;
  localparam int CAP_W       = 5;
  localparam int DEF_ENTRIES = 16;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [ACT_W-1:0] {
    ACT_UPDATE = 2'd0,
    ACT_LOOKUP = 2'd1,
    ACT_BEST   = 2'd2,
    ACT_UNUSED = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_SET,
    OP_INSERT,
    OP_SWAP,
    OP_DROP
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE,
    ST_ADJ,
    ST_ADJ_END,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic accept;
    logic rd_scan;
    logic rd_adj;
    logic decide;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic idx_last;
    logic need_adj;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

[hw/rtl/pfsbf_ctrl.sv]
// sequencer for scan, decision, rank adjust pass and result hand-off
`default_nettype none
module pfsbf_ctrl
  import pfsbf_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  status_t      status,
  output cmd_t         cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.rd_scan = 1'b1;
        if (status.idx_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      // last entry read is compared here
      ST_DRAIN: begin
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = status.need_adj ? ST_ADJ : ST_FINISH;
      end
      ST_ADJ: begin
        cmd.rd_adj = 1'b1;
        if (status.idx_last) begin
          state_nxt = ST_ADJ_END;
        end
      end
      // last rank write-back
      ST_ADJ_END: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[hw/rtl/pfsbf_dp.sv]
// entry store, scan comparators, rank adjust and result register
`default_nettype none
module pfsbf_dp
  import pfsbf_pkg::*;
#(
  parameter int ENTRIES = DEF_ENTRIES
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  cmd_t                    cmd,
  output status_t                 status,
  input  wire logic [ACT_W-1:0]   in_action,
  input  wire logic [ID_W-1:0]    in_key_id,
  input  wire logic [SPACE_W-1:0] in_space_value,
  input  wire logic               cfg_wr_en,
  input  wire logic [CAP_W-1:0]   cfg_wr_data,
  input  wire logic               out_stall,
  output logic                    out_valid,
  output logic                    out_found,
  output logic [ID_W-1:0]         out_result_id,
  output logic [SPACE_W-1:0]      out_result_space,
  output logic                    out_table_empty
);

  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RANK_W = IDX_W;
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [SPACE_W-1:0] space;
    logic [RANK_W-1:0]  rank;
  } word_t;

  word_t mem [ENTRIES];

  logic [ENTRIES-1:0] valid_r;
  logic [CNT_W-1:0]   count_r;
  logic [CAP_W-1:0]   capacity_r;

  // current word
  action_t            act_r;
  logic [ID_W-1:0]    key_r;
  logic [SPACE_W-1:0] val_r;

  // read pipeline
  logic [IDX_W-1:0] rd_idx_r;
  word_t            pipe_word_r;
  logic             pipe_v_r;
  logic [IDX_W-1:0] pipe_idx_r;
  logic             pipe_scan_r;
  logic             pipe_adj_r;

  // scan results
  logic               match_f_r;
  logic [IDX_W-1:0]   match_idx_r;
  logic [SPACE_W-1:0] match_space_r;
  logic [RANK_W-1:0]  match_rank_r;
  logic               free_f_r;
  logic [IDX_W-1:0]   free_idx_r;
  logic               least_f_r;
  logic [IDX_W-1:0]   least_idx_r;
  logic [SPACE_W-1:0] least_space_r;
  logic [RANK_W-1:0]  least_rank_r;
  logic               best_f_r;
  logic [ID_W-1:0]    best_id_r;
  logic [SPACE_W-1:0] best_space_r;
  logic [RANK_W-1:0]  best_rank_r;

  // decision
  op_t               op_nxt, op_r;
  logic [IDX_W-1:0]  slot_nxt, slot_r;
  logic [RANK_W-1:0] slot_rank_nxt, slot_rank_r;

  logic               out_valid_r;
  logic               out_found_r;
  logic [ID_W-1:0]    out_id_r;
  logic [SPACE_W-1:0] out_space_r;
  logic               out_empty_r;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  word_t            wr_data;

  logic [CMP_W-1:0] cap_ext, ent_ext, cap_eff, cnt_ext;
  logic             rd_issue;
  logic             is_last;

  assign rd_issue = cmd.rd_scan | cmd.rd_adj;
  assign is_last  = (rd_idx_r == IDX_W'(ENTRIES - 1));

  assign cap_ext = CMP_W'(capacity_r);
  assign ent_ext = CMP_W'(ENTRIES);
  assign cap_eff = (cap_ext > ent_ext) ? ent_ext : cap_ext;
  assign cnt_ext = CMP_W'(count_r);

  // update decision from the finished scan
  always_comb begin
    op_nxt        = OP_NONE;
    slot_nxt      = match_idx_r;
    slot_rank_nxt = match_rank_r;
    if (act_r == ACT_UPDATE) begin
      if (match_f_r) begin
        op_nxt = (val_r == '0) ? OP_DROP : OP_SET;
      end else if (val_r != '0) begin
        if (cnt_ext < cap_eff) begin
          if (free_f_r) begin
            op_nxt   = OP_INSERT;
            slot_nxt = free_idx_r;
          end
        end else if (cnt_ext == cap_eff && count_r != '0 && least_f_r &&
                     val_r > least_space_r) begin
          op_nxt        = OP_SWAP;
          slot_nxt      = least_idx_r;
          slot_rank_nxt = least_rank_r;
        end
      end
    end
  end

  assign status.idx_last = is_last;
  assign status.need_adj = (op_nxt == OP_INSERT) || (op_nxt == OP_SWAP) ||
                           (op_nxt == OP_DROP);
  assign status.out_free = !out_valid_r || !out_stall;

  // single write port: space overwrite at decide, else rank pass write-back
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pipe_idx_r;
    wr_data = pipe_word_r;
    if (cmd.decide && op_nxt == OP_SET) begin
      wr_en   = 1'b1;
      wr_addr = match_idx_r;
      wr_data = '{id: key_r, space: val_r, rank: match_rank_r};
    end else if (pipe_adj_r) begin
      if (pipe_idx_r == slot_r) begin
        wr_en   = (op_r == OP_INSERT) || (op_r == OP_SWAP);
        wr_data = '{id: key_r, space: val_r, rank: '0};
      end else if (pipe_v_r) begin
        wr_en = 1'b1;
        unique case (op_r)
          OP_INSERT: wr_data.rank = pipe_word_r.rank + RANK_W'(1);
          OP_SWAP: begin
            if (pipe_word_r.rank < slot_rank_r) begin
              wr_data.rank = pipe_word_r.rank + RANK_W'(1);
            end
          end
          OP_DROP: begin
            if (pipe_word_r.rank > slot_rank_r) begin
              wr_data.rank = pipe_word_r.rank - RANK_W'(1);
            end
          end
          default: wr_en = 1'b0;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_issue) begin
      pipe_word_r <= mem[rd_idx_r];
      pipe_v_r    <= valid_r[rd_idx_r];
      pipe_idx_r  <= rd_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pipe_scan_r <= 1'b0;
      pipe_adj_r  <= 1'b0;
      rd_idx_r    <= '0;
    end else begin
      pipe_scan_r <= cmd.rd_scan;
      pipe_adj_r  <= cmd.rd_adj;
      if (cmd.accept || cmd.decide || (rd_issue && is_last)) begin
        rd_idx_r <= '0;
      end else if (rd_issue) begin
        rd_idx_r <= rd_idx_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      act_r <= action_t'(in_action);
      key_r <= in_key_id;
      val_r <= in_space_value;
    end
    if (cmd.decide) begin
      op_r        <= op_nxt;
      slot_r      <= slot_nxt;
      slot_rank_r <= slot_rank_nxt;
    end
  end

  // scan comparators, one entry a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_f_r <= 1'b0;
      free_f_r  <= 1'b0;
      least_f_r <= 1'b0;
      best_f_r  <= 1'b0;
    end else if (cmd.accept) begin
      match_f_r <= 1'b0;
      free_f_r  <= 1'b0;
      least_f_r <= 1'b0;
      best_f_r  <= 1'b0;
    end else if (pipe_scan_r) begin
      if (pipe_v_r && pipe_word_r.id == key_r && !match_f_r) begin
        match_f_r     <= 1'b1;
        match_idx_r   <= pipe_idx_r;
        match_space_r <= pipe_word_r.space;
        match_rank_r  <= pipe_word_r.rank;
      end
      if (!pipe_v_r && !free_f_r) begin
        free_f_r   <= 1'b1;
        free_idx_r <= pipe_idx_r;
      end
      if (pipe_v_r && (!least_f_r || pipe_word_r.space < least_space_r ||
          (pipe_word_r.space == least_space_r && pipe_word_r.rank < least_rank_r))) begin
        least_f_r     <= 1'b1;
        least_idx_r   <= pipe_idx_r;
        least_space_r <= pipe_word_r.space;
        least_rank_r  <= pipe_word_r.rank;
      end
      if (pipe_v_r && pipe_word_r.space >= val_r &&
          (!best_f_r || pipe_word_r.space < best_space_r ||
          (pipe_word_r.space == best_space_r && pipe_word_r.rank < best_rank_r))) begin
        best_f_r     <= 1'b1;
        best_id_r    <= pipe_word_r.id;
        best_space_r <= pipe_word_r.space;
        best_rank_r  <= pipe_word_r.rank;
      end
    end
  end

  // occupancy and capacity
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      count_r    <= '0;
      capacity_r <= CAP_RESET;
    end else begin
      if (cfg_wr_en) begin
        capacity_r <= cfg_wr_data;
      end
      if (cmd.decide) begin
        unique case (op_nxt)
          OP_INSERT: begin
            valid_r[slot_nxt] <= 1'b1;
            count_r           <= count_r + CNT_W'(1);
          end
          OP_DROP: begin
            valid_r[slot_nxt] <= 1'b0;
            count_r           <= count_r - CNT_W'(1);
          end
          default: ;
        endcase
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_empty_r <= (count_r == '0);
      out_found_r <= 1'b0;
      out_id_r    <= '0;
      out_space_r <= '0;
      if (act_r == ACT_LOOKUP && match_f_r) begin
        out_found_r <= 1'b1;
        out_id_r    <= key_r;
        out_space_r <= match_space_r;
      end else if (act_r == ACT_BEST && best_f_r) begin
        out_found_r <= 1'b1;
        out_id_r    <= best_id_r;
        out_space_r <= best_space_r;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_result_id    = out_id_r;
  assign out_result_space = out_space_r;
  assign out_table_empty  = out_empty_r;

endmodule
`default_nettype wire

[hw/rtl/page_free_space_best_fit_table_core.sv]
// top level of the page free space best-fit table
//
//  channel  direction  handshake          payload
//  in_      input      in_valid/in_stall  action, key_id, space_value
//  out_     output     out_valid/out_stall found, result_id, result_space, table_empty
//  cfg_     input      cfg_wr_en          cfg_wr_data (capacity)
//
// each word scans all ENTRIES slots, one memory read a cycle, then decides: lookup,
// best fit and no-change updates then finish, while inserts, swaps and removals add
// a rank adjust pass over the same read port.
// reset empties the table by clearing the valid bits; capacity resets to 16.
// a new word is taken while a result waits in the output register; a stalled
// output holds the block at its last step until the register frees.
`default_nettype none
module page_free_space_best_fit_table_core
  import pfsbf_pkg::*;
#(
  parameter int ENTRIES = DEF_ENTRIES
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [ACT_W-1:0]   in_action,
  input  wire logic [ID_W-1:0]    in_key_id,
  input  wire logic [SPACE_W-1:0] in_space_value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_found,
  output logic [ID_W-1:0]         out_result_id,
  output logic [SPACE_W-1:0]      out_result_space,
  output logic                    out_table_empty,
  input  wire logic               cfg_wr_en,
  input  wire logic [CAP_W-1:0]   cfg_wr_data
);

  cmd_t    cmd;
  status_t status;

  pfsbf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  pfsbf_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_action        (in_action),
    .in_key_id        (in_key_id),
    .in_space_value   (in_space_value),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_found        (out_found),
    .out_result_id    (out_result_id),
    .out_result_space (out_result_space),
    .out_table_empty  (out_table_empty)
  );

endmodule
`default_nettype wire

[verif/page_free_space_best_fit_table_core_test.sv]
// self-checking testbench for the page free space best-fit table core
`timescale 1ns / 1ps
module page_free_space_best_fit_table_core_test;
  import pfsbf_pkg::*;

  localparam int SETTLE_CYCLES = 2 * DEF_ENTRIES + 16;
  localparam int POOL_SIZE     = 24;

  typedef struct packed {
    logic               found;
    logic [ID_W-1:0]    id;
    logic [SPACE_W-1:0] space;
    logic               empty;
  } table_reply_t;

  typedef struct {
    logic [ID_W-1:0]    id;
    logic [SPACE_W-1:0] space;
  } page_entry_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [ACT_W-1:0]   in_action = ACT_UPDATE;
  logic [ID_W-1:0]    in_key_id = '0;
  logic [SPACE_W-1:0] in_space_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_found;
  logic [ID_W-1:0]    out_result_id;
  logic [SPACE_W-1:0] out_result_space;
  logic               out_table_empty;
  logic               cfg_wr_en = 1'b0;
  logic [CAP_W-1:0]   cfg_wr_data = '0;

  // model of the table: index 0 is the most recent entry
  page_entry_t        recency_list[$];
  logic [CAP_W-1:0]   capacity_reg = CAP_RESET;
  table_reply_t       expected_replies[$];
  logic [ID_W-1:0]    id_pool [POOL_SIZE];
  int                 fault_count = 0;
  int                 tx_calm = 0;
  int                 rx_calm = 0;
  int                 stall_left = 0;

  page_free_space_best_fit_table_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_key_id        (in_key_id),
    .in_space_value   (in_space_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_found        (out_found),
    .out_result_id    (out_result_id),
    .out_result_space (out_result_space),
    .out_table_empty  (out_table_empty),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic table_reply_t predict_table_step(input action_t act,
                                                      input logic [ID_W-1:0] key,
                                                      input logic [SPACE_W-1:0] space);
    table_reply_t reply;
    int hit;
    int pick;
    int limit;
    reply = '0;
    hit = -1;
    pick = -1;
    limit = (capacity_reg > DEF_ENTRIES) ? DEF_ENTRIES : int'(capacity_reg);
    foreach (recency_list[i])
      if (hit < 0 && recency_list[i].id == key) hit = i;
    case (act)
      ACT_UPDATE: begin
        if (hit >= 0) begin
          if (space == '0) recency_list.delete(hit);
          else recency_list[hit].space = space;
        end else if (space != '0) begin
          if (recency_list.size() < limit) begin
            recency_list.push_front(page_entry_t'{key, space});
          end else if (recency_list.size() == limit && limit != 0) begin
            // least free space, the most recent entry on a tie
            foreach (recency_list[i])
              if (pick < 0 || recency_list[i].space < recency_list[pick].space) pick = i;
            if (space > recency_list[pick].space) begin
              recency_list.delete(pick);
              recency_list.push_front(page_entry_t'{key, space});
            end
          end
        end
      end
      ACT_LOOKUP: begin
        if (hit >= 0) begin
          reply.found = 1'b1;
          reply.id    = recency_list[hit].id;
          reply.space = recency_list[hit].space;
        end
      end
      ACT_BEST: begin
        foreach (recency_list[i])
          if (recency_list[i].space >= space &&
              (pick < 0 || recency_list[i].space < recency_list[pick].space)) pick = i;
        if (pick >= 0) begin
          reply.found = 1'b1;
          reply.id    = recency_list[pick].id;
          reply.space = recency_list[pick].space;
        end
      end
      default: ;
    endcase
    reply.empty = (recency_list.size() == 0);
    return reply;
  endfunction

  function automatic void check_field(input string field, input logic [ID_W-1:0] want,
                                      input logic [ID_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      fault_count++;
    end
  endfunction

  function automatic logic [SPACE_W-1:0] draw_space();
    case ($urandom_range(0, 3))
      0: return SPACE_W'($urandom_range(1, 8));
      1: return SPACE_W'($urandom_range(1, 64));
      default: return SPACE_W'($urandom);
    endcase
  endfunction

  // result side: compare each accepted word, then draw the stall for the next one
  always @(posedge clk) begin : reply_check
    table_reply_t want;
    int n;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (out_valid && !out_stall) begin
      if (expected_replies.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual found %0b id %0d space %0d empty %0b",
                 $time, out_found, out_result_id, out_result_space, out_table_empty);
        fault_count++;
      end else begin
        want = expected_replies.pop_front();
        check_field("found", ID_W'(want.found), ID_W'(out_found));
        check_field("result_id", want.id, out_result_id);
        check_field("result_space", ID_W'(want.space), ID_W'(out_result_space));
        check_field("table_empty", ID_W'(want.empty), ID_W'(out_table_empty));
      end
      if (rx_calm > 0) begin
        rx_calm <= rx_calm - 1;
        n = 0;
      end else begin
        n = $urandom_range(0, 12);
        if ($urandom_range(0, 19) == 0) rx_calm <= $urandom_range(10, 40);
      end
      out_stall  <= (n != 0);
      stall_left <= n;
    end else if (out_valid && out_stall) begin
      // the stall only counts down once a word is waiting
      if (stall_left <= 1) out_stall <= 1'b0;
      else stall_left <= stall_left - 1;
    end
  end

  task automatic send_word(input action_t act, input logic [ID_W-1:0] key,
                           input logic [SPACE_W-1:0] space);
    int gap;
    if (tx_calm > 0) begin
      tx_calm--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 12);
      if ($urandom_range(0, 19) == 0) tx_calm = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_action      <= act;
    in_key_id      <= key;
    in_space_value <= space;
    expected_replies.push_back(predict_table_step(act, key, space));
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic settle_block();
    in_valid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] cap);
    settle_block();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cap;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    capacity_reg = cap;
  endtask

  task automatic test_empty_table();
    send_word(ACT_LOOKUP, 31'd7, 15'd0);
    send_word(ACT_BEST, 31'd0, 15'd0);
    send_word(ACT_UNUSED, {ID_W{1'b1}}, {SPACE_W{1'b1}});
    send_word(ACT_UPDATE, 31'd5, 15'd0);
  endtask

  task automatic test_update_lookup();
    send_word(ACT_UPDATE, 31'd0, {SPACE_W{1'b1}});
    send_word(ACT_UPDATE, {ID_W{1'b1}}, 15'd1);
    send_word(ACT_LOOKUP, 31'd0, 15'd0);
    send_word(ACT_LOOKUP, {ID_W{1'b1}}, {SPACE_W{1'b1}});
    send_word(ACT_LOOKUP, 31'd12345, 15'd0);
    send_word(ACT_UPDATE, {ID_W{1'b1}}, 15'd200);
    send_word(ACT_BEST, 31'd99, 15'd0);
    send_word(ACT_BEST, 31'd0, 15'd201);
    send_word(ACT_BEST, 31'd0, {SPACE_W{1'b1}});
    send_word(ACT_UPDATE, 31'd0, 15'd0);
    send_word(ACT_BEST, 31'd0, 15'd201);
    send_word(ACT_UNUSED, 31'd1, 15'd1);
  endtask

  task automatic test_capacity_limits();
    set_capacity(5'd2);
    send_word(ACT_UPDATE, 31'd10, 15'd50);
    send_word(ACT_UPDATE, 31'd11, 15'd50);  // full, not above the least: ignored
    send_word(ACT_UPDATE, 31'd11, 15'd51);  // evicts the least free entry
    send_word(ACT_LOOKUP, 31'd10, 15'd0);
    send_word(ACT_BEST, 31'd0, 15'd40);
    set_capacity(5'd0);
    send_word(ACT_UPDATE, 31'd12, 15'd9);
    send_word(ACT_UPDATE, 31'd11, 15'd0);
    set_capacity(5'd1);
    send_word(ACT_UPDATE, 31'd13, 15'd100);
    send_word(ACT_UPDATE, 31'd13, 15'd300);
    send_word(ACT_LOOKUP, 31'd13, 15'd0);
    set_capacity(5'd31);
    send_word(ACT_UPDATE, 31'd14, 15'd7);
    send_word(ACT_BEST, 31'd0, 15'd0);
  endtask

  task automatic run_random_phase(input logic [CAP_W-1:0] cap, input int count);
    int span;
    int roll;
    int limit;
    logic [ID_W-1:0] key;
    logic [SPACE_W-1:0] space;
    set_capacity(cap);
    limit = (cap > DEF_ENTRIES) ? DEF_ENTRIES : int'(cap);
    span = (limit + 6 > POOL_SIZE) ? POOL_SIZE : limit + 6;
    // keep most ids so that entries from the last phase stay reachable
    repeat (4) id_pool[$urandom_range(0, POOL_SIZE - 1)] = ID_W'($urandom);
    repeat (count) begin
      roll = $urandom_range(0, 99);
      key = ($urandom_range(0, 9) == 0) ? ID_W'($urandom) : id_pool[$urandom_range(0, span - 1)];
      if (roll < 50) begin
        space = ($urandom_range(0, 6) == 0) ? '0 : draw_space();
        send_word(ACT_UPDATE, key, space);
      end else if (roll < 70) begin
        send_word(ACT_LOOKUP, key, SPACE_W'($urandom));
      end else if (roll < 95) begin
        space = ($urandom_range(0, 9) == 0) ? '0 : draw_space();
        send_word(ACT_BEST, ID_W'($urandom), space);
      end else begin
        send_word(ACT_UNUSED, ID_W'($urandom), SPACE_W'($urandom));
      end
    end
  endtask

  task automatic test_random_traffic();
    foreach (id_pool[i]) id_pool[i] = ID_W'($urandom);
    run_random_phase(5'd16, 220);
    run_random_phase(5'd5, 170);
    run_random_phase(5'd1, 150);
    run_random_phase(5'd0, 120);
    run_random_phase(5'd31, 200);
    run_random_phase(5'd3, 160);
    run_random_phase(5'd17, 170);
    run_random_phase(CAP_W'($urandom_range(0, 31)), 160);
    run_random_phase(5'd16, 150);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_table();
    test_update_lookup();
    test_capacity_limits();
    test_random_traffic();
    settle_block();
    if (fault_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #8000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
